>>> rtl/core/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, switched off while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/itm_pkg.sv
// Shared constants, widths and control/status types of the trace packet decoder.
package itm_pkg;

    localparam int CHANNELS      = 10;
    localparam int PENDING_DEPTH = 16;

    localparam int BYTE_W       = 8;
    localparam int CHAN_FIELD_W = 5;
    localparam int VALUE_W      = 32;
    localparam int TIME_W       = 28;
    localparam int ERR_W        = 16;
    localparam int OUT_CH_W     = 4;
    localparam int M_DATA_W     = 80;
    localparam int M_USER_W     = 5;

    localparam int CHAN_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
    localparam int PEND_W  = CHAN_FIELD_W + VALUE_W;

    // Timestamp continuation bytes past this count add nothing.
    localparam int TS_GROUPS = 4;

    localparam logic [BYTE_W-1:0] HDR_SIZE_MASK   = 8'h03;
    localparam logic [BYTE_W-1:0] HDR_CHAN_MASK   = 8'hF8;
    localparam logic [BYTE_W-1:0] TS_VALUE_MASK   = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_BIT        = 8'h80;
    localparam logic [BYTE_W-1:0] OVERFLOW_HDR    = 8'h70;
    localparam logic [BYTE_W-1:0] LOW_NIBBLE_MASK = 8'h0F;

    localparam logic [1:0] SIZE_FOUR = 2'd3;
    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    typedef struct packed {
        logic hdr_src;
        logic hdr_ts;
        logic ts_multi;
        logic pay_done;
        logic byte_more;
        logic walk_done;
        logic chan_bad;
        logic emit_last;
    } itm_status_t;

    typedef struct packed {
        logic hdr_load;
        logic pay_take;
        logic time_start;
        logic time_take;
        logic ts_short;
        logic walk_start;
        logic walk_read;
        logic walk_apply;
        logic frame_finish;
        logic emit_next;
    } itm_cmd_t;

endpackage

>>> rtl/core/itm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/itm_ctrl.sv
// Sequence controller: packet parsing states and the frame close walk.
module itm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  itm_pkg::itm_status_t st,
    output itm_pkg::itm_cmd_t    cmd
);
    import itm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAYLOAD,
        ST_TIME,
        ST_READ,
        ST_APPLY,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   s_acc;

    assign s_acc = s_tvalid & s_tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (st.hdr_src) begin
                        cmd.hdr_load = 1'b1;
                        state_next   = ST_PAYLOAD;
                    end else if (st.hdr_ts) begin
                        if (st.ts_multi) begin
                            cmd.time_start = 1'b1;
                            state_next     = ST_TIME;
                        end else begin
                            cmd.ts_short   = 1'b1;
                            cmd.walk_start = 1'b1;
                            state_next     = ST_READ;
                        end
                    end
                end
            end
            ST_PAYLOAD: begin
                if (s_acc) begin
                    cmd.pay_take = 1'b1;
                    if (st.pay_done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TIME: begin
                if (s_acc) begin
                    cmd.time_take = 1'b1;
                    if (!st.byte_more) begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (st.walk_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.walk_read = 1'b1;
                    state_next    = ST_APPLY;
                end
            end
            ST_APPLY: begin
                // A channel beyond range stops the walk; earlier entries stay applied.
                cmd.walk_apply = 1'b1;
                state_next     = st.chan_bad ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                cmd.frame_finish = 1'b1;
                state_next       = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    cmd.emit_next = 1'b1;
                    if (st.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready_next = state_next inside {ST_IDLE, ST_PAYLOAD, ST_TIME};
    assign m_tvalid_next = (state_next == ST_EMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> rtl/core/itm_dp.sv
// Datapath: byte classification, payload and timestamp gathering, pending list and held values.
module itm_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [itm_pkg::BYTE_W-1:0]    s_byte,
    input  itm_pkg::itm_cmd_t             cmd,
    output itm_pkg::itm_status_t          st,
    output logic [itm_pkg::OUT_CH_W-1:0]  channel_index,
    output logic [itm_pkg::VALUE_W-1:0]   channel_value,
    output logic [itm_pkg::TIME_W-1:0]    time_delta,
    output logic                          last_of_frame,
    output logic                          bad_frame,
    output logic [itm_pkg::ERR_W-1:0]     error_total
);
    import itm_pkg::*;

    logic [2:0]              payload_left_reg;
    logic [1:0]              payload_pos_reg;
    logic [CHAN_FIELD_W-1:0] hdr_chan_reg;
    logic [VALUE_W-1:0]      value_reg;
    logic [TIME_W-1:0]       time_reg;
    logic [2:0]              seen_reg;
    logic [PEND_CW-1:0]      pend_count_reg;
    logic [PEND_CW-1:0]      walk_idx_reg;
    logic                    frame_bad_reg;
    logic                    out_bad_reg;
    logic [ERR_W-1:0]        err_reg;
    logic [CHAN_W-1:0]       emit_idx_reg;
    logic [VALUE_W-1:0]      held_reg [CHANNELS];

    logic [1:0]              size_code;
    logic [VALUE_W-1:0]      value_next;
    logic [4:0]              ts_shamt;
    logic [TIME_W-1:0]       ts_group;
    logic                    pend_room;
    logic                    ram_we;
    logic [PEND_W-1:0]       ram_rdata;
    logic [CHAN_FIELD_W-1:0] rd_chan;
    logic [VALUE_W-1:0]      rd_val;

    assign size_code = s_byte[1:0] & HDR_SIZE_MASK[1:0];

    assign st.hdr_src   = ((s_byte & HDR_SIZE_MASK) != '0);
    assign st.hdr_ts    = (s_byte != OVERFLOW_HDR) && ((s_byte & LOW_NIBBLE_MASK) == '0)
                          && ((s_byte & OVERFLOW_HDR) != '0);
    assign st.ts_multi  = ((s_byte & CONT_BIT) != '0);
    assign st.byte_more = ((s_byte & CONT_BIT) != '0);
    assign st.pay_done  = (payload_left_reg <= 3'd1);
    assign st.walk_done = (walk_idx_reg == pend_count_reg);
    assign st.chan_bad  = (rd_chan >= CHAN_FIELD_W'(CHANNELS));
    assign st.emit_last = (emit_idx_reg == CHAN_W'(CHANNELS - 1));

    // Payload bytes land little-endian at the current byte lane.
    assign value_next = value_reg | (VALUE_W'(s_byte) << {payload_pos_reg, 3'b000});
    assign ts_shamt   = {3'b000, seen_reg[1:0]} * 5'd7;
    assign ts_group   = TIME_W'(s_byte & TS_VALUE_MASK) << ts_shamt;
    assign pend_room  = (pend_count_reg < PEND_CW'(PENDING_DEPTH));
    assign ram_we     = cmd.pay_take && st.pay_done && pend_room;

    assign rd_chan = ram_rdata[PEND_W-1:VALUE_W];
    assign rd_val  = ram_rdata[VALUE_W-1:0];

    itm_ram #(
        .WIDTH (PEND_W),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pend_count_reg[PEND_AW-1:0]),
        .wdata ({hdr_chan_reg, value_next}),
        .re    (cmd.walk_read),
        .raddr (walk_idx_reg[PEND_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_left_reg <= '0;
            payload_pos_reg  <= '0;
            hdr_chan_reg     <= '0;
            value_reg        <= '0;
            time_reg         <= '0;
            seen_reg         <= '0;
            pend_count_reg   <= '0;
            walk_idx_reg     <= '0;
            frame_bad_reg    <= 1'b0;
            out_bad_reg      <= 1'b0;
            err_reg          <= '0;
            emit_idx_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                held_reg[i] <= '0;
            end
        end else begin
            if (cmd.hdr_load) begin
                payload_left_reg <= (size_code == SIZE_FOUR) ? 3'd4 : {1'b0, size_code};
                payload_pos_reg  <= '0;
                hdr_chan_reg     <= CHAN_FIELD_W'((s_byte & HDR_CHAN_MASK) >> 3);
                value_reg        <= '0;
            end
            if (cmd.pay_take) begin
                value_reg       <= value_next;
                payload_pos_reg <= payload_pos_reg + 2'd1;
                if (payload_left_reg != 3'd0) begin
                    payload_left_reg <= payload_left_reg - 3'd1;
                end
                if (st.pay_done) begin
                    if (pend_room) begin
                        pend_count_reg <= pend_count_reg + PEND_CW'(1);
                    end else begin
                        frame_bad_reg <= 1'b1;
                    end
                end
            end
            if (cmd.time_start) begin
                time_reg <= '0;
                seen_reg <= '0;
            end
            if (cmd.time_take && (seen_reg < 3'(TS_GROUPS))) begin
                time_reg <= time_reg | ts_group;
                seen_reg <= seen_reg + 3'd1;
            end
            if (cmd.ts_short) begin
                time_reg <= TIME_W'((s_byte & TS_VALUE_MASK) >> 4);
            end
            if (cmd.walk_start) begin
                walk_idx_reg <= '0;
            end
            if (cmd.walk_apply) begin
                if (st.chan_bad) begin
                    frame_bad_reg <= 1'b1;
                end else begin
                    held_reg[rd_chan[CHAN_W-1:0]] <= rd_val;
                    walk_idx_reg <= walk_idx_reg + PEND_CW'(1);
                end
            end
            if (cmd.frame_finish) begin
                if (frame_bad_reg && (err_reg != ERR_MAX)) begin
                    err_reg <= err_reg + ERR_W'(1);
                end
                out_bad_reg    <= frame_bad_reg;
                frame_bad_reg  <= 1'b0;
                pend_count_reg <= '0;
                emit_idx_reg   <= '0;
            end
            if (cmd.emit_next && !st.emit_last) begin
                emit_idx_reg <= emit_idx_reg + CHAN_W'(1);
            end
        end
    end

    assign channel_index = OUT_CH_W'(emit_idx_reg);
    assign channel_value = held_reg[emit_idx_reg];
    assign time_delta    = time_reg;
    assign last_of_frame = st.emit_last;
    assign bad_frame     = out_bad_reg;
    assign error_total   = err_reg;

endmodule

>>> rtl/core/itm_trace_packet_decoder.sv
// Top level of the trace packet decoder: controller, datapath and stream ports.
//
//  Port group | Direction | Contents
//  s_         | in        | s_tdata[7:0] = trace_byte
//  m_         | out       | m_tdata: channel_value, time_delta, error_total; m_tuser: channel_index,
//             |           | bad_frame; m_tlast = last_of_frame
//
// Header, payload and timestamp bytes are accepted back to back until a frame closes.
// A frame close reads and applies each pending entry in turn (pending RAM read, then the
// held value write) until the list ends or a channel beyond range stops the walk, then a
// finish step, and one result transfer per channel, one per cycle while m_tready is high.
// No byte is taken from the time a frame closes until its last result is transferred.
// aresetn is synchronous and clears parser state, counters and all held channel values.
module itm_trace_packet_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [itm_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] trace_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] channel_value, [59:32] time_delta, [75:60] error_total, [79:76] zero
    output logic [itm_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [itm_pkg::M_USER_W-1:0]   m_tuser,   // [3:0] channel_index, [4] bad_frame
    output logic                           m_tlast
);
    import itm_pkg::*;

    itm_status_t          st;
    itm_cmd_t             cmd;
    logic [OUT_CH_W-1:0]  channel_index;
    logic [VALUE_W-1:0]   channel_value;
    logic [TIME_W-1:0]    time_delta;
    logic                 last_of_frame;
    logic                 bad_frame;
    logic [ERR_W-1:0]     error_total;

    itm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    itm_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_byte        (s_tdata),
        .cmd           (cmd),
        .st            (st),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .time_delta    (time_delta),
        .last_of_frame (last_of_frame),
        .bad_frame     (bad_frame),
        .error_total   (error_total)
    );

    assign m_tdata = M_DATA_W'({error_total, time_delta, channel_value});
    assign m_tuser = {bad_frame, channel_index};
    assign m_tlast = last_of_frame;

endmodule

>>> rtl/core/itm_checker.sv
// Port-level checks of the trace packet decoder and their binding to the top level.
`include "assert_macros.svh"

module itm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [itm_pkg::M_DATA_W-1:0] m_tdata,
    input logic [itm_pkg::M_USER_W-1:0] m_tuser,
    input logic                         m_tlast
);
    import itm_pkg::*;

    logic                         m_stall;
    logic                         mid_xfer;
    logic                         last_xfer;
    logic [M_DATA_W+M_USER_W:0]   m_word;
    logic [OUT_CH_W-1:0]          chan_now;
    logic [OUT_CH_W-1:0]          chan_inc;

    assign m_stall   = m_tvalid && !m_tready;
    assign mid_xfer  = m_tvalid && m_tready && !m_tlast;
    assign last_xfer = m_tvalid && m_tready && m_tlast;
    assign m_word    = {m_tdata, m_tuser, m_tlast};
    assign chan_now  = m_tuser[OUT_CH_W-1:0];
    assign chan_inc  = chan_now + OUT_CH_W'(1);

    // A stalled result keeps its contents.
    `ASSERT_CLK(a_out_hold, m_stall |=> (m_tvalid && $stable(m_word)), "stalled result changed")

    // Bytes are never taken while results of a frame are being delivered.
    `ASSERT_CLK(a_no_overlap, !(s_tready && m_tvalid), "input ready while results pending")

    // Channel results of one frame come out in ascending order without gaps.
    `ASSERT_CLK(a_chan_step, mid_xfer |=> (m_tvalid && chan_now == $past(chan_inc)), "channel order")

    // The frame ends after its last result transfer.
    `ASSERT_CLK(a_frame_end, last_xfer |=> !m_tvalid, "results continue past frame end")

    // Reset leaves no result pending.
    `ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind itm_trace_packet_decoder itm_checker u_checker (.*);
